// ===== hdl/gms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_pkg : shared types and constants
// Register map, configuration bundle and sequencer states of the Gillespie
// mutation step block.
// ----------------------------------------------------------------------------
package gms_pkg;

	// APB address width: seven 32-bit registers at byte offsets 4*i
	localparam int APB_AW = 5;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_POPULATION = 3'd0;
	localparam logic [2:0] REG_TIME_LIMIT = 3'd1;
	localparam logic [2:0] REG_FITNESS0   = 3'd2;
	localparam logic [2:0] REG_FITNESS1   = 3'd3;
	localparam logic [2:0] REG_FITNESS2   = 3'd4;
	localparam logic [2:0] REG_MUT1       = 3'd5;
	localparam logic [2:0] REG_MUT2       = 3'd6;

	// reset values
	localparam logic [15:0] POPULATION_RST = 16'd100;
	localparam logic [31:0] TIME_LIMIT_RST = 32'd25600;
	localparam logic [15:0] FITNESS_RST    = 16'd4096;
	localparam logic [15:0] MUT_RST        = 16'd0;

	// ln(2) in Q0.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// number of squarings for the log2 fraction
	localparam int LOG_FRAC_BITS = 24;

	typedef struct packed {
		logic [15:0] population;
		logic [31:0] time_limit;
		logic [15:0] fitness_type0;
		logic [15:0] fitness_type1;
		logic [15:0] fitness_type2;
		logic [15:0] mutation_into_type1;
		logic [15:0] mutation_into_type2;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FN_M, ST_FN_A,
		ST_W_M0, ST_W_A0, ST_W_M1, ST_W_A1,
		ST_T_M0, ST_T_A0, ST_T_M1, ST_T_A1,
		ST_CHECK,
		ST_LN_NORM, ST_LN_M, ST_LN_A,
		ST_L2_M, ST_L2_A,
		ST_PS_M0, ST_PS_A0, ST_PS_M1, ST_PS_A1,
		ST_DIV_GO, ST_DIV,
		ST_TIME,
		ST_X_M0, ST_X_A0, ST_X_M1, ST_X_A1,
		ST_PICK,
		ST_DONE
	} gms_state_t;

endpackage

// ===== hdl/gms_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_channels : request and response channels
// Valid/ready channels carrying one request and one result per transfer.
// ----------------------------------------------------------------------------
interface gms_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] uniform_time;
	logic [15:0] uniform_pick;

	modport source (output valid, output req_type, output uniform_time,
		output uniform_pick, input ready);
	modport sink (input valid, input req_type, input uniform_time,
		input uniform_pick, output ready);
endinterface

interface gms_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_index;
	logic [1:0]  from_type;
	logic [1:0]  to_type;
	logic [31:0] time_step;
	logic [31:0] elapsed_time;
	logic        stopped;
	logic [15:0] count_type0;
	logic [15:0] count_type1;
	logic [15:0] count_type2;
	logic        fixed;

	modport source (output valid, output event_index, output from_type, output to_type,
		output time_step, output elapsed_time, output stopped, output count_type0,
		output count_type1, output count_type2, output fixed, input ready);
	modport sink (input valid, input event_index, input from_type, input to_type,
		input time_step, input elapsed_time, input stopped, input count_type0,
		input count_type1, input count_type2, input fixed, output ready);
endinterface

// ===== hdl/gms_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_regs : APB configuration registers
// Seven model registers, written on the APB access phase, read back as is.
// ----------------------------------------------------------------------------
module gms_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gms_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output gms_pkg::cfg_t               cfg
);
	import gms_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.population          <= POPULATION_RST;
			cfg_q.time_limit          <= TIME_LIMIT_RST;
			cfg_q.fitness_type0       <= FITNESS_RST;
			cfg_q.fitness_type1       <= FITNESS_RST;
			cfg_q.fitness_type2       <= FITNESS_RST;
			cfg_q.mutation_into_type1 <= MUT_RST;
			cfg_q.mutation_into_type2 <= MUT_RST;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_POPULATION: cfg_q.population          <= pwdata[15:0];
				REG_TIME_LIMIT: cfg_q.time_limit          <= pwdata;
				REG_FITNESS0:   cfg_q.fitness_type0       <= pwdata[15:0];
				REG_FITNESS1:   cfg_q.fitness_type1       <= pwdata[15:0];
				REG_FITNESS2:   cfg_q.fitness_type2       <= pwdata[15:0];
				REG_MUT1:       cfg_q.mutation_into_type1 <= pwdata[15:0];
				REG_MUT2:       cfg_q.mutation_into_type2 <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[4:2])
			REG_POPULATION: prdata = {16'd0, cfg_q.population};
			REG_TIME_LIMIT: prdata = cfg_q.time_limit;
			REG_FITNESS0:   prdata = {16'd0, cfg_q.fitness_type0};
			REG_FITNESS1:   prdata = {16'd0, cfg_q.fitness_type1};
			REG_FITNESS2:   prdata = {16'd0, cfg_q.fitness_type2};
			REG_MUT1:       prdata = {16'd0, cfg_q.mutation_into_type1};
			REG_MUT2:       prdata = {16'd0, cfg_q.mutation_into_type2};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/gms_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_mul : shared multiplier
// One 32x32 unsigned multiplier with a registered product, time-shared by
// the sequencer for every product of the step.
// ----------------------------------------------------------------------------
module gms_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule

// ===== hdl/gms_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_div : iterative divider
// Restoring unsigned division, one quotient bit per cycle; done pulses for
// one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module gms_div #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    rem_sh;
	logic          ge;

	// shift in next dividend bit and trial-subtract
	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign ge       = rem_sh >= {1'b0, divisor};
	assign done     = done_q;
	assign quotient = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

endmodule

// ===== hdl/gillespie_mutation_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gillespie_mutation_step : one Gillespie step of a three-type mutation model
// Sequencer around one shared multiplier and an iterative divider.
// A reaction step's time from the request transfer to the result is set by 24
// squarings on the multiplier, the divider and the mantissa normalisation; a
// step that stops on a zero total rate skips these, and start requests and
// steps after a stop go straight to the result.
// Throughput: one request at a time; ready is high only while idle.
// Reset: asynchronous, active low; counts and time cleared, run stopped,
// registers at their documented reset values.
// ----------------------------------------------------------------------------
module gillespie_mutation_step #(
	parameter int NUM_TYPES  = 3,
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gms_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	gms_req_if.sink                     req,
	gms_rsp_if.source                   rsp
);
	import gms_pkg::*;

	localparam int NT = NUM_TYPES;
	localparam int NE = NT * (NT - 1);
	localparam int IW = (NT > 2) ? 2 : 1;
	localparam int KW = $clog2(NE);
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	cfg_t cfg;

	gms_state_t state_q, state_d;

	// model state
	logic [COUNT_BITS-1:0] n_q [NT];
	logic [31:0]           sim_time_q;
	logic                  run_stopped_q;

	// sequencer counters
	logic [IW-1:0] i_q, j_q;
	logic [KW-1:0] k_q;
	logic [4:0]    it_q;

	// working registers
	logic [31:0] fn_q [NT];
	logic [49:0] w_q  [NT];
	logic [63:0] cum_q [NE];
	logic [33:0] s_q;
	logic [63:0] t_q;
	logic [31:0] m_q;
	logic [3:0]  e_q;
	logic [23:0] frac_q;
	logic [27:0] ln_q;
	logic [61:0] num_q;
	logic [79:0] x_q;
	logic [15:0] ut_q, up_q;
	logic [31:0] tstep_q;
	logic [2:0]  ev_q;
	logic [1:0]  from_q, to_q;

	// result register
	logic        out_valid_q;
	logic [2:0]  out_ev_q;
	logic [1:0]  out_from_q, out_to_q;
	logic [31:0] out_tstep_q, out_time_q;
	logic        out_stop_q, out_fixed_q;
	logic [15:0] out_cnt_q [3];

	// shared units
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        div_done;
	logic [63:0] div_quo;

	// helpers
	logic                  accept, out_free, i_last, pair_last, pick_hit;
	logic                  stop_zero, time_over;
	logic [IW-1:0]         i_adv, j_adv, n_idx, fn_idx;
	logic [2:0]            jn, inx;
	logic [COUNT_BITS-1:0] n_rd, pop_sat, cnt2;
	logic [63:0]           cum_rd, nt_sum, t_hi_add;
	logic [28:0]           l2;
	logic [31:0]           sq;
	logic [15:0]           cnt_out [3];

	gms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gms_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	gms_div #(.W(64)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIV_GO),
		.dividend ({2'b00, num_q}),
		.divisor  (t_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	function automatic logic [15:0] fit_sel(input logic [1:0] idx, input cfg_t c);
		logic [15:0] r;
		unique case (idx)
			2'd0:    r = c.fitness_type0;
			2'd1:    r = c.fitness_type1;
			2'd2:    r = c.fitness_type2;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// mutation probability into type idx; none past the last type
	function automatic logic [15:0] mut_sel(input logic [1:0] idx, input cfg_t c);
		logic [15:0] r;
		r = 16'd0;
		if (idx == 2'd1 && NT > 1) r = c.mutation_into_type1;
		else if (idx == 2'd2 && NT > 2) r = c.mutation_into_type2;
		return r;
	endfunction

	// handshake
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// (to, from) walk in row-major order, from advancing fastest, skipping the diagonal
	always_comb begin
		jn  = 3'(j_q) + 3'd1;
		inx = 3'(i_q);
		if (jn == inx) jn = jn + 3'd1;
		if (jn >= 3'(NT)) begin
			inx = inx + 3'd1;
			jn  = 3'd0;
		end
		i_adv = IW'(inx);
		j_adv = IW'(jn);
	end

	assign i_last    = (i_q == IW'(NT - 1));
	assign pair_last = (i_q == IW'(NT - 1)) && (j_q == IW'(NT - 2));

	// read selects
	assign n_idx  = (state_q == ST_T_M0 || state_q == ST_T_M1) ? j_q : i_q;
	assign fn_idx = (state_q == ST_W_M1) ? (i_q - IW'(1)) : i_q;
	assign n_rd   = n_q[n_idx];
	assign cum_rd = cum_q[k_q];

	// decisions
	assign stop_zero = (t_q == 64'd0) || (ut_q == 16'd0);
	assign nt_sum    = {32'd0, sim_time_q} + div_quo;
	assign time_over = nt_sum > {32'd0, cfg.time_limit};
	assign pick_hit  = x_q <= {cum_rd, 16'd0};
	assign t_hi_add  = t_q + {mul_p[31:0], 32'd0};
	assign l2        = {5'(5'd16 - {1'b0, e_q}), 24'd0} - {5'd0, frac_q};
	assign sq        = mul_p[61:30];
	assign pop_sat   = COUNT_BITS'(({16'd0, cfg.population} > CNT_MAX) ?
		CNT_MAX : {16'd0, cfg.population});

	// multiplier operand selection
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (state_q)
			ST_FN_M: begin
				mul_a = 32'(n_rd);
				mul_b = 32'(fit_sel(2'(i_q), cfg));
			end
			ST_W_M0: begin
				mul_a = fn_q[fn_idx];
				mul_b = 32'(17'h10000 - {1'b0, mut_sel(2'(i_q) + 2'd1, cfg)});
			end
			ST_W_M1: begin
				mul_a = fn_q[fn_idx];
				mul_b = 32'(mut_sel(2'(i_q), cfg));
			end
			ST_T_M0: begin
				mul_a = w_q[i_q][31:0];
				mul_b = 32'(n_rd);
			end
			ST_T_M1: begin
				mul_a = 32'(w_q[i_q][49:32]);
				mul_b = 32'(n_rd);
			end
			ST_LN_M: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_L2_M: begin
				mul_a = 32'(l2);
				mul_b = LN2_Q32;
			end
			ST_PS_M0: begin
				mul_a = s_q[31:0];
				mul_b = 32'(ln_q);
			end
			ST_PS_M1: begin
				mul_a = 32'(s_q[33:32]);
				mul_b = 32'(ln_q);
			end
			ST_X_M0: begin
				mul_a = t_q[31:0];
				mul_b = 32'(up_q);
			end
			ST_X_M1: begin
				mul_a = t_q[63:32];
				mul_b = 32'(up_q);
			end
			default: ;
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!req.req_type || run_stopped_q) state_d = ST_DONE;
					else                                state_d = ST_FN_M;
				end
			end
			ST_FN_M:  state_d = ST_FN_A;
			ST_FN_A:  state_d = i_last ? ST_W_M0 : ST_FN_M;
			ST_W_M0:  state_d = ST_W_A0;
			ST_W_A0: begin
				if (i_q != '0)  state_d = ST_W_M1;
				else if (i_last) state_d = ST_T_M0;
				else             state_d = ST_W_M0;
			end
			ST_W_M1:  state_d = ST_W_A1;
			ST_W_A1:  state_d = i_last ? ST_T_M0 : ST_W_M0;
			ST_T_M0:  state_d = ST_T_A0;
			ST_T_A0:  state_d = ST_T_M1;
			ST_T_M1:  state_d = ST_T_A1;
			ST_T_A1:  state_d = pair_last ? ST_CHECK : ST_T_M0;
			ST_CHECK: state_d = stop_zero ? ST_DONE : ST_LN_NORM;
			ST_LN_NORM: state_d = m_q[30] ? ST_LN_M : ST_LN_NORM;
			ST_LN_M:  state_d = ST_LN_A;
			ST_LN_A:  state_d = (it_q == 5'(LOG_FRAC_BITS - 1)) ? ST_L2_M : ST_LN_M;
			ST_L2_M:  state_d = ST_L2_A;
			ST_L2_A:  state_d = ST_PS_M0;
			ST_PS_M0: state_d = ST_PS_A0;
			ST_PS_A0: state_d = ST_PS_M1;
			ST_PS_M1: state_d = ST_PS_A1;
			ST_PS_A1: state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV:   state_d = div_done ? ST_TIME : ST_DIV;
			ST_TIME:  state_d = (time_over || up_q == 16'd0) ? ST_DONE : ST_X_M0;
			ST_X_M0:  state_d = ST_X_A0;
			ST_X_A0:  state_d = ST_X_M1;
			ST_X_M1:  state_d = ST_X_A1;
			ST_X_A1:  state_d = ST_PICK;
			ST_PICK:  state_d = (pick_hit || pair_last) ? ST_DONE : ST_PICK;
			ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// model state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) n_q[t] <= '0;
			sim_time_q    <= 32'd0;
			run_stopped_q <= 1'b1;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			it_q          <= 5'd0;
			out_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !req.req_type) begin
						for (int t = 0; t < NT; t++) n_q[t] <= (t == 0) ? pop_sat : '0;
						sim_time_q    <= 32'd0;
						run_stopped_q <= 1'b0;
					end
					i_q <= '0;
				end
				ST_FN_A: i_q <= i_last ? '0 : i_q + IW'(1);
				ST_W_A0: begin
					if (i_q == '0) i_q <= i_q + IW'(1);
				end
				ST_W_A1: begin
					if (i_last) begin
						i_q <= '0;
						j_q <= IW'(1);
						k_q <= '0;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_T_A1: begin
					if (!pair_last) begin
						i_q <= i_adv;
						j_q <= j_adv;
						k_q <= k_q + KW'(1);
					end
				end
				ST_CHECK: begin
					if (stop_zero) run_stopped_q <= 1'b1;
					it_q <= 5'd0;
				end
				ST_LN_A: it_q <= it_q + 5'd1;
				ST_TIME: begin
					if (time_over) run_stopped_q <= 1'b1;
					else           sim_time_q    <= nt_sum[31:0];
					i_q <= '0;
					j_q <= IW'(1);
					k_q <= '0;
				end
				ST_PICK: begin
					if (pick_hit) begin
						for (int t = 0; t < NT; t++) begin
							if (IW'(t) == j_q)      n_q[t] <= n_q[t] - COUNT_BITS'(1);
							else if (IW'(t) == i_q) n_q[t] <= n_q[t] + COUNT_BITS'(1);
						end
					end else if (!pair_last) begin
						i_q <= i_adv;
						j_q <= j_adv;
						k_q <= k_q + KW'(1);
					end
				end
				default: ;
			endcase
			// result valid
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready)                 out_valid_q <= 1'b0;
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ut_q    <= req.uniform_time;
					up_q    <= req.uniform_pick;
					ev_q    <= 3'd0;
					from_q  <= 2'd0;
					to_q    <= 2'd0;
					tstep_q <= 32'd0;
					s_q     <= 34'd0;
					t_q     <= 64'd0;
				end
			end
			ST_FN_A: begin
				fn_q[i_q] <= mul_p[31:0];
				s_q       <= s_q + {2'b00, mul_p[31:0]};
			end
			ST_W_A0: w_q[i_q] <= mul_p[49:0];
			ST_W_A1: w_q[i_q] <= w_q[i_q] + mul_p[49:0];
			ST_T_A0: t_q <= t_q + mul_p;
			ST_T_A1: begin
				t_q        <= t_hi_add;
				cum_q[k_q] <= t_hi_add;
			end
			ST_CHECK: begin
				if (stop_zero) tstep_q <= 32'hFFFF_FFFF;
				m_q    <= {1'b0, ut_q, 15'd0};
				e_q    <= 4'd15;
				frac_q <= 24'd0;
			end
			// normalise mantissa to Q1.30
			ST_LN_NORM: begin
				if (!m_q[30]) begin
					m_q <= {m_q[30:0], 1'b0};
					e_q <= e_q - 4'd1;
				end
			end
			// one log2 fraction bit per squaring
			ST_LN_A: begin
				frac_q <= {frac_q[22:0], sq[31]};
				m_q    <= sq[31] ? {1'b0, sq[31:1]} : sq;
			end
			ST_L2_A:  ln_q  <= mul_p[59:32];
			ST_PS_A0: num_q <= mul_p[61:0];
			ST_PS_A1: num_q <= num_q + {mul_p[29:0], 32'd0};
			ST_TIME:  tstep_q <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
			ST_X_A0:  x_q <= {16'd0, mul_p};
			ST_X_A1:  x_q <= x_q + {mul_p[47:0], 32'd0};
			ST_PICK: begin
				if (pick_hit) begin
					ev_q   <= 3'(k_q) + 3'd1;
					from_q <= 2'(j_q);
					to_q   <= 2'(i_q);
				end
			end
			default: ;
		endcase
	end

	// count views for the result
	always_comb begin
		cnt2 = '0;
		for (int t = 0; t < 3; t++) cnt_out[t] = 16'd0;
		for (int t = 0; t < NT; t++) begin
			cnt_out[t] = 16'(n_q[t]);
			if (t == 2) cnt2 = n_q[t];
		end
	end

	// result register load
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_ev_q    <= ev_q;
			out_from_q  <= from_q;
			out_to_q    <= to_q;
			out_tstep_q <= tstep_q;
			out_time_q  <= sim_time_q;
			out_stop_q  <= run_stopped_q;
			out_fixed_q <= (32'(cnt2) == {16'd0, cfg.population});
			for (int t = 0; t < 3; t++) out_cnt_q[t] <= cnt_out[t];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.event_index  = out_ev_q;
	assign rsp.from_type    = out_from_q;
	assign rsp.to_type      = out_to_q;
	assign rsp.time_step    = out_tstep_q;
	assign rsp.elapsed_time = out_time_q;
	assign rsp.stopped      = out_stop_q;
	assign rsp.count_type0  = out_cnt_q[0];
	assign rsp.count_type1  = out_cnt_q[1];
	assign rsp.count_type2  = out_cnt_q[2];
	assign rsp.fixed        = out_fixed_q;

	// a start request goes straight to the result
	a_start_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !req.req_type) |=> (state_q == ST_DONE))
		else $error("start request did not complete directly");

	// the divider only finishes while the sequencer waits on it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	// a chosen event always moves between two different types
	a_event_types: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.event_index == 3'd0) || (rsp.from_type != rsp.to_type))
		else $error("event with equal from and to types");

	// a stopped run never reports an event
	a_stop_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.stopped) |-> (rsp.event_index == 3'd0))
		else $error("event reported on a stopped run");

endmodule

// ===== verif/gms_test_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_test_channels : channel interfaces for the testbench build
// The block's own request and result channels are used as they stand; this
// file only carries the shared APB bundle used by stimulus and checker.
// ----------------------------------------------------------------------------
interface gms_apb_if;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [gms_pkg::APB_AW-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	modport source (output psel, output penable, output pwrite, output paddr,
		output pwdata, input prdata, input pready);
	modport sink (input psel, input penable, input pwrite, input paddr,
		input pwdata, output prdata, output pready);
endinterface

// ===== verif/gms_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_step_checker : predicts and checks the Gillespie step results
// Watches register writes and request transfers, computes the expected result
// of each request, and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
module gms_step_checker (
	input  logic       clk,
	input  logic       arst_n,
	gms_apb_if         apb,
	gms_req_if         req,
	gms_rsp_if         rsp,
	output int         fail_count,
	output int         pending
);
	import gms_pkg::*;

	typedef struct packed {
		logic [2:0]  event_index;
		logic [1:0]  from_type;
		logic [1:0]  to_type;
		logic [31:0] time_step;
		logic [31:0] elapsed_time;
		logic        stopped;
		logic [15:0] count_type0;
		logic [15:0] count_type1;
		logic [15:0] count_type2;
		logic        fixed;
	} step_result_t;

	cfg_t           cfg;
	logic [15:0]    counts [3];
	logic [31:0]    sim_clock;
	logic           halted;
	step_result_t   expected_steps [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// -ln(v/65536) in Q.24
	function automatic logic [63:0] neg_log_q24(input logic [15:0] v);
		int          msb;
		logic [63:0] mant, frac, l2;
		msb = 0;
		frac = 0;
		for (int b = 15; b >= 0; b--)
			if (v[b]) begin
				msb = b;
				break;
			end
		mant = 64'(v) << (30 - msb);
		for (int b = 0; b < 24; b++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= 64'd1 << 31) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		l2 = (64'd16 << 24) - ((64'(msb) << 24) + frac);
		return 64'((128'(l2) * 128'(LN2_Q32)) >> 32);
	endfunction

	function automatic step_result_t predict_step(input logic rq, input logic [15:0] ut,
			input logic [15:0] up);
		step_result_t r;
		logic [63:0]  fit [3], mu [4], w [3], n [3];
		logic [63:0]  s, t, delta, nt, cum;
		logic [127:0] scaled;
		int           k;
		bit           found;
		r = '0;
		s = 0;
		t = 0;
		if (rq == 1'b0) begin
			counts[0] = cfg.population;
			counts[1] = 0;
			counts[2] = 0;
			sim_clock = 0;
			halted = 1'b0;
		end else if (!halted) begin
			fit[0] = cfg.fitness_type0;
			fit[1] = cfg.fitness_type1;
			fit[2] = cfg.fitness_type2;
			mu[0] = 0;
			mu[1] = cfg.mutation_into_type1;
			mu[2] = cfg.mutation_into_type2;
			mu[3] = 0;
			for (int i = 0; i < 3; i++) n[i] = counts[i];
			for (int i = 0; i < 3; i++) s += fit[i] * n[i];
			for (int i = 0; i < 3; i++) begin
				w[i] = (64'd65536 - mu[i + 1]) * fit[i] * n[i];
				if (i > 0) w[i] += mu[i] * fit[i - 1] * n[i - 1];
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (i != j) t += w[i] * n[j];
			if (t == 0 || ut == 0) begin
				halted = 1'b1;
				r.time_step = '1;
			end else begin
				delta = 64'((128'(neg_log_q24(ut)) * 128'(s)) / 128'(t));
				nt = 64'(sim_clock) + delta;
				r.time_step = (delta > 64'hFFFF_FFFF) ? '1 : delta[31:0];
				if (nt > 64'(cfg.time_limit)) begin
					halted = 1'b1;
				end else begin
					sim_clock = nt[31:0];
					if (up != 0) begin
						scaled = 128'(t) * 128'(up);
						cum = 0;
						k = 0;
						found = 0;
						for (int i = 0; i < 3 && !found; i++)
							for (int j = 0; j < 3 && !found; j++) begin
								if (i == j) continue;
								k++;
								cum += w[i] * n[j];
								if (scaled <= (128'(cum) << 16)) begin
									found = 1;
									r.event_index = k[2:0];
									r.from_type = j[1:0];
									r.to_type = i[1:0];
								end
							end
						if (found) begin
							counts[r.from_type] = counts[r.from_type] - 16'd1;
							counts[r.to_type] = counts[r.to_type] + 16'd1;
						end
					end
				end
			end
		end
		r.elapsed_time = sim_clock;
		r.stopped = halted;
		r.count_type0 = counts[0];
		r.count_type1 = counts[1];
		r.count_type2 = counts[2];
		r.fixed = (counts[2] == cfg.population);
		return r;
	endfunction

	// register writes, request prediction and result comparison
	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			cfg = '{POPULATION_RST, TIME_LIMIT_RST, FITNESS_RST, FITNESS_RST, FITNESS_RST,
				MUT_RST, MUT_RST};
			counts = '{default: '0};
			sim_clock = 0;
			halted = 1'b1;
			expected_steps.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (apb.psel && apb.penable && apb.pwrite && apb.pready)
				case (apb.paddr[4:2])
					REG_POPULATION: cfg.population = apb.pwdata[15:0];
					REG_TIME_LIMIT: cfg.time_limit = apb.pwdata;
					REG_FITNESS0:   cfg.fitness_type0 = apb.pwdata[15:0];
					REG_FITNESS1:   cfg.fitness_type1 = apb.pwdata[15:0];
					REG_FITNESS2:   cfg.fitness_type2 = apb.pwdata[15:0];
					REG_MUT1:       cfg.mutation_into_type1 = apb.pwdata[15:0];
					REG_MUT2:       cfg.mutation_into_type2 = apb.pwdata[15:0];
					default: ;
				endcase
			if (rsp.valid && rsp.ready) begin
				if (expected_steps.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = expected_steps.pop_front();
					if (rsp.event_index !== want.event_index)
						report("event_index", rsp.event_index, want.event_index);
					if (rsp.from_type !== want.from_type)
						report("from_type", rsp.from_type, want.from_type);
					if (rsp.to_type !== want.to_type)
						report("to_type", rsp.to_type, want.to_type);
					if (rsp.time_step !== want.time_step)
						report("time_step", rsp.time_step, want.time_step);
					if (rsp.elapsed_time !== want.elapsed_time)
						report("elapsed_time", rsp.elapsed_time, want.elapsed_time);
					if (rsp.stopped !== want.stopped)
						report("stopped", rsp.stopped, want.stopped);
					if (rsp.count_type0 !== want.count_type0)
						report("count_type0", rsp.count_type0, want.count_type0);
					if (rsp.count_type1 !== want.count_type1)
						report("count_type1", rsp.count_type1, want.count_type1);
					if (rsp.count_type2 !== want.count_type2)
						report("count_type2", rsp.count_type2, want.count_type2);
					if (rsp.fixed !== want.fixed)
						report("fixed", rsp.fixed, want.fixed);
				end
			end
			if (req.valid && req.ready)
				expected_steps.insert(expected_steps.size(),
					predict_step(req.req_type, req.uniform_time, req.uniform_pick));
			pending = expected_steps.size();
		end
	end

endmodule

// ===== verif/gillespie_mutation_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gillespie_mutation_step_test : top of the Gillespie step testbench
// Writes the registers through several settings, sends directed and random
// start and step requests under varying idling, and gives the verdict.
// ----------------------------------------------------------------------------
module gillespie_mutation_step_test;
	import gms_pkg::*;

	localparam int SETTLE_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   take_idle_pct;
	bit   hold_off;

	gms_apb_if apb ();
	gms_req_if req ();
	gms_rsp_if rsp ();

	gillespie_mutation_step dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (apb.psel),
		.penable (apb.penable),
		.pwrite  (apb.pwrite),
		.paddr   (apb.paddr),
		.pwdata  (apb.pwdata),
		.prdata  (apb.prdata),
		.pready  (apb.pready),
		.req     (req),
		.rsp     (rsp)
	);

	gms_step_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.apb        (apb),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#60_000_000;
		$display("gillespie_mutation_step_test failed");
		$finish;
	end

	// result side: random stall, or a long hold-off when asked
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_off)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// setup then access phase; psel stays up for a following write
	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		apb.psel <= 1'b1;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b1;
		apb.paddr <= {index, 2'b00};
		apb.pwdata <= value;
		@(posedge clk);
		apb.penable <= 1'b1;
		@(posedge clk);
	endtask

	// valid stays up after the transfer until the next request or a drain
	task automatic send_request(input logic rq, input logic [15:0] ut, input logic [15:0] up);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rq;
		req.uniform_time <= ut;
		req.uniform_pick <= up;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(input logic [15:0] pop, input logic [31:0] lim,
			input logic [15:0] f0, input logic [15:0] f1, input logic [15:0] f2,
			input logic [15:0] m1, input logic [15:0] m2);
		drain();
		write_reg(REG_POPULATION, {16'd0, pop});
		write_reg(REG_TIME_LIMIT, lim);
		write_reg(REG_FITNESS0, {16'd0, f0});
		write_reg(REG_FITNESS1, {16'd0, f1});
		write_reg(REG_FITNESS2, {16'd0, f2});
		write_reg(REG_MUT1, {16'd0, m1});
		write_reg(REG_MUT2, {16'd0, m2});
		apb.psel <= 1'b0;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b0;
	endtask

	// one run: start, then a burst of mostly step requests, with an occasional restart, with random uniforms
	task automatic random_run(input int steps);
		send_request(1'b0, 16'($urandom), 16'($urandom));
		for (int s = 0; s < steps; s++)
			send_request(($urandom_range(19) != 0), 16'($urandom_range(65535, 1)),
				($urandom_range(15) == 0) ? 16'(0) : 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		apb.psel = 1'b0;
		apb.penable = 1'b0;
		apb.pwrite = 1'b0;
		apb.paddr = '0;
		apb.pwdata = '0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.uniform_time = '0;
		req.uniform_pick = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: step before any start, reset settings
		send_request(1'b1, 16'd1000, 16'd1000);
		send_request(1'b0, 16'hFFFF, 16'hFFFF);
		send_request(1'b1, 16'hFFFF, 16'hFFFF);
		send_request(1'b1, 16'd1, 16'd0);
		send_request(1'b1, 16'h8000, 16'h0001);
		send_request(1'b1, 16'h0000, 16'h1234);
		send_request(1'b1, 16'd5, 16'd5);
		// mutation on, all fitness extremes
		load_setting(16'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(1'b0, 16'd0, 16'd0);
		for (int i = 0; i < 8; i++) send_request(1'b1, 16'h5555, 16'hFFFF);
		send_request(1'b1, 16'd1, 16'h0001);
		// zero fitness: total rate zero
		load_setting(16'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(1'b0, 16'hAAAA, 16'h5555);
		send_request(1'b1, 16'hAAAA, 16'h5555);
		// largest population, tight limit
		load_setting(16'hFFFF, 32'd1, 16'h1000, 16'h2000, 16'h0800, 16'h8000, 16'h0100);
		send_request(1'b0, 16'd1, 16'd1);
		send_request(1'b1, 16'hFFFF, 16'h8000);
		send_request(1'b1, 16'hFFFF, 16'h8000);

		// random phases with varying idling and settings
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 31 : (ph < 8) ? 71 : 0;
			take_idle_pct = (ph < 4) ? 71 : (ph < 8) ? 31 : 0;
			load_setting(16'($urandom_range(12, 2)), $urandom_range(32'h0040_0000, 32'd50),
				16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(65535, 4000)), 16'($urandom_range(65535, 4000)));
			for (int r = 0; r < 4; r++) random_run(25);
			if (ph == 5) begin
				// long receiver hold-off while requests keep coming
				hold_off = 1'b1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_off = 1'b0;
					end
					random_run(6);
				join
			end
		end
		load_setting(16'd100, 32'd25600, 16'd4096, 16'd4096, 16'd4096, 16'd0, 16'd0);
		random_run(30);

		drain();
		if (fail_count == 0)
			$display("gillespie_mutation_step_test passed");
		else
			$display("gillespie_mutation_step_test failed");
		$finish;
	end

endmodule
